// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker module.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the async active-low reset is asserted.
`define CW_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Clocked assertion that is also checked during reset.
`define CW_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ----- rtl/core/ble_cw_pkg.sv -----
// Package for the BLE CRC-24 / whitening encoder: constants, types, LFSR functions.
// No dependencies.
package ble_cw_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CrcW  = 24;
  localparam int unsigned ChanW = 6;

  localparam logic [CrcW-1:0]  CrcInit   = 24'h555555;
  localparam logic [CrcW-1:0]  CrcTaps   = 24'h00065B;
  localparam logic [ByteW-1:0] WhtTaps   = 8'h11;
  localparam logic [ByteW-1:0] SeedForce = 8'h02;
  localparam logic [ChanW-1:0] ChanReset = 6'd37;

  // CRC bytes left to send after the last data word
  localparam logic [1:0] TailHi  = 2'd3;
  localparam logic [1:0] TailMid = 2'd2;
  localparam logic [1:0] TailLo  = 2'd1;
  localparam logic [1:0] TailNone = 2'd0;

  typedef struct packed {
    logic       tail;
    logic [1:0] cnt;
  } path_ctl_t;

  typedef struct packed {
    logic [ByteW-1:0] state;
    logic [ByteW-1:0] data;
  } wht_res_t;

  function automatic logic [ByteW-1:0] rev8(input logic [ByteW-1:0] a);
    logic [ByteW-1:0] r;
    for (int i = 0; i < ByteW; i++) begin
      r[ByteW-1-i] = a[i];
    end
    return r;
  endfunction

  function automatic logic [ByteW-1:0] seed_of(input logic [ChanW-1:0] chan);
    return rev8({2'b00, chan}) | SeedForce;
  endfunction

  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                                input logic [ByteW-1:0] d);
    logic [CrcW-1:0] c;
    logic            fb;
    c = crc;
    for (int i = 0; i < ByteW; i++) begin
      fb = c[CrcW-1] ^ d[i];
      c  = {c[CrcW-2:0], 1'b0};
      if (fb) begin
        c = c ^ CrcTaps;
      end
    end
    return c;
  endfunction

  function automatic wht_res_t whiten_byte(input logic [ByteW-1:0] w,
                                           input logic [ByteW-1:0] d);
    wht_res_t r;
    r.state = w;
    r.data  = d;
    for (int i = 0; i < ByteW; i++) begin
      if (r.state[ByteW-1]) begin
        r.state   = r.state ^ WhtTaps;
        r.data[i] = ~r.data[i];
      end
      r.state = {r.state[ByteW-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/ble_cw_byte_path.sv -----
// Per-word datapath: CRC update of a data word and whitening of a data or CRC word.
// Depends on ble_cw_pkg.
module ble_cw_byte_path import ble_cw_pkg::*; (
  input  logic [CrcW-1:0]  crc_i,
  input  logic [ByteW-1:0] wht_i,
  input  logic [ByteW-1:0] data_i,
  input  path_ctl_t        ctl_i,
  output logic [CrcW-1:0]  crc_o,
  output logic [ByteW-1:0] wht_o,
  output logic [ByteW-1:0] byte_o
);

  logic [ByteW-1:0] crc_sel;
  logic [ByteW-1:0] src;
  wht_res_t         wres;

  always_comb begin
    case (ctl_i.cnt)
      TailHi:  crc_sel = crc_i[23:16];
      TailMid: crc_sel = crc_i[15:8];
      default: crc_sel = crc_i[7:0];
    endcase
    src    = ctl_i.tail ? rev8(crc_sel) : data_i;
    wres   = whiten_byte(wht_i, src);
    wht_o  = wres.state;
    byte_o = wres.data;
    crc_o  = crc_byte(crc_i, data_i);
  end

endmodule

// ----- rtl/core/ble_adv_crc_whiten_encoder_top.sv -----
// BLE CRC-24 and whitening encoder, top level with state and output registers.
// Depends on ble_cw_pkg and ble_cw_byte_path.
//
// Input channel (in_valid_i/in_ready_o) takes one packet word per cycle while
// in_ready_o is high, with last_in_i marking the final header/payload word.
// Output channel (out_valid_o/out_ready_i) gives each whitened word; after the
// last data word three whitened, bit-reversed CRC words follow, high byte first,
// the third with last_out_o set.
// A result is registered and appears in the cycle after its word is accepted.
// Data words are taken one per cycle unless the output stalls or a CRC tail is
// pending; a word with last_in_i set is followed in the output register by three
// CRC words, and in_ready_o stays low while these are being loaded.
// cfg_we_i writes the channel (cfg_wdata_i) and reseeds both LFSRs at once.
// Reset: channel 37, CRC 0x555555, whitening seed of channel 37, output empty.
// When the receiver stalls, the output word holds and in_ready_o drops until
// the output register can be reloaded.
module ble_adv_crc_whiten_encoder_top import ble_cw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             last_in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] out_byte_o,
  output logic             last_out_o,
  input  logic             cfg_we_i,
  input  logic [ChanW-1:0] cfg_wdata_i
);

  logic [CrcW-1:0]  crc_q, crc_d;
  logic [ByteW-1:0] wht_q, wht_d;
  logic [ChanW-1:0] chan_q, chan_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             ov_q, ov_d;
  logic [ByteW-1:0] ob_q, ob_d;
  logic             ol_q, ol_d;

  logic             load_ok, accept, tail_go;
  path_ctl_t        ctl;
  logic [CrcW-1:0]  p_crc;
  logic [ByteW-1:0] p_wht, p_byte;

  assign load_ok    = !ov_q || out_ready_i;
  assign in_ready_o = load_ok && (cnt_q == TailNone);
  assign accept     = in_valid_i && in_ready_o;
  assign tail_go    = load_ok && (cnt_q != TailNone);
  assign ctl.tail   = cnt_q != TailNone;
  assign ctl.cnt    = cnt_q;

  ble_cw_byte_path u_path (
    .crc_i  (crc_q),
    .wht_i  (wht_q),
    .data_i (data_byte_i),
    .ctl_i  (ctl),
    .crc_o  (p_crc),
    .wht_o  (p_wht),
    .byte_o (p_byte)
  );

  always_comb begin
    crc_d  = crc_q;
    wht_d  = wht_q;
    chan_d = chan_q;
    cnt_d  = cnt_q;
    ov_d   = ov_q && !out_ready_i;
    ob_d   = ob_q;
    ol_d   = ol_q;
    if (accept) begin
      crc_d = p_crc;
      wht_d = p_wht;
      ob_d  = p_byte;
      ol_d  = 1'b0;
      ov_d  = 1'b1;
      cnt_d = last_in_i ? TailHi : TailNone;
    end else if (tail_go) begin
      wht_d = p_wht;
      ob_d  = p_byte;
      ol_d  = (cnt_q == TailLo);
      ov_d  = 1'b1;
      cnt_d = cnt_q - 2'd1;
      if (cnt_q == TailLo) begin
        crc_d = CrcInit;
        wht_d = seed_of(chan_q);
      end
    end
    if (cfg_we_i) begin
      chan_d = cfg_wdata_i;
      crc_d  = CrcInit;
      wht_d  = seed_of(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= CrcInit;
      wht_q  <= seed_of(ChanReset);
      chan_q <= ChanReset;
      cnt_q  <= TailNone;
      ov_q   <= 1'b0;
    end else begin
      crc_q  <= crc_d;
      wht_q  <= wht_d;
      chan_q <= chan_d;
      cnt_q  <= cnt_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ob_q <= ob_d;
    ol_q <= ol_d;
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = ob_q;
  assign last_out_o  = ol_q;

endmodule

// ----- rtl/core/ble_cw_checker.sv -----
// Port-level checker for the BLE CRC-24 / whitening encoder, bound to the top level.
// Depends on ble_cw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ble_cw_checker import ble_cw_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             last_in_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [ByteW-1:0] out_byte_o,
  input logic             last_out_o
);

  logic in_acc, out_acc, out_stall;
  assign in_acc    = in_valid_i && in_ready_o;
  assign out_acc   = out_valid_o && out_ready_i;
  assign out_stall = out_valid_o && !out_ready_i;

  `CW_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_o)

  `CW_ASSERT(a_out_stable, clk_i, rst_ni, out_stall |=> $stable({out_byte_o, last_out_o}))

  // CRC tail blocks new words
  `CW_ASSERT(a_tail_blocks, clk_i, rst_ni, in_acc && last_in_i |=> !in_ready_o)

  // a data word shows up next cycle, never flagged as end of packet
  `CW_ASSERT(a_data_next, clk_i, rst_ni, in_acc |=> out_valid_o && !last_out_o)

  // nothing follows the final CRC word unless a new word came in
  `CW_ASSERT(a_end_empty, clk_i, rst_ni, out_acc && last_out_o && !in_acc |=> !out_valid_o)

endmodule

bind ble_adv_crc_whiten_encoder_top ble_cw_checker u_ble_cw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .last_in_i   (last_in_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_byte_o  (out_byte_o),
  .last_out_o  (last_out_o)
);
